// ===== src/s7_response_pdu_parser_macros.svh =====
// Assertion macros shared by the S7 response PDU parser modules.
// Each macro expects clk and arst_n to be visible at the point of use.
`ifndef S7_RESPONSE_PDU_PARSER_MACROS_SVH
`define S7_RESPONSE_PDU_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define S7RP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define S7RP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/s7rp_pkg.sv =====
// Shared types and constants of the S7 response PDU parser.
// Used by the front end, the result queue, the back end and the top level.
package s7rp_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 8;
	localparam int TDATA_W = 120;
	localparam int TUSER_W = 3;
	localparam int S_TDATA_W = 8;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] REG_PROTOCOL_ID = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ACK_DATA_TYPE = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_SIZE_BIT = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_SIZE_BYTE = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_SIZE_INT = 3'd4;

	// Register reset values.
	localparam logic [7:0] RST_PROTOCOL_ID = 8'd50;
	localparam logic [7:0] RST_ACK_DATA_TYPE = 8'd3;
	localparam logic [7:0] RST_SIZE_BIT = 8'd3;
	localparam logic [7:0] RST_SIZE_BYTE = 8'd4;
	localparam logic [7:0] RST_SIZE_INT = 8'd5;

	// Header lengths and item header size.
	localparam logic [3:0] HDR_LEN_PLAIN = 4'd10;
	localparam logic [3:0] HDR_LEN_ACK = 4'd12;
	localparam logic [15:0] ITEM_HDR_LEN = 16'd4;

	// Error codes carried in value_byte of an error result.
	localparam logic [7:0] ERR_BAD_ID = 8'd0;
	localparam logic [7:0] ERR_SHORT_HDR = 8'd1;
	localparam logic [7:0] ERR_SHORT_FRAME = 8'd2;
	localparam logic [7:0] ERR_ITEM_OVERRUN = 8'd3;

	typedef enum logic [2:0] {
		KIND_HDR = 3'd0,
		KIND_PARAM = 3'd1,
		KIND_ITEM_HDR = 3'd2,
		KIND_ITEM = 3'd3,
		KIND_FRAME = 3'd4,
		KIND_ERR = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_PARAM = 3'd1,
		PH_ITEM_HDR = 3'd2,
		PH_ITEM_DATA = 3'd3,
		PH_PAD = 3'd4,
		PH_TAIL = 3'd5,
		PH_DONE = 3'd6,
		PH_SKIP = 3'd7
	} phase_t;

	// Header and item values shown with every result of one input byte.
	typedef struct packed {
		logic [15:0] item_bytes;
		logic [7:0] item_size_code;
		logic [7:0] item_return_code;
		logic [15:0] ack_error;
		logic [15:0] data_length;
		logic [15:0] param_length;
		logic [15:0] pdu_reference;
		logic [7:0] msg_type;
	} snap_t;

	// Everything one input byte produces: up to two results.
	typedef struct packed {
		logic [1:0] count;
		kind_t kind0;
		logic [7:0] value0;
		logic item_end0;
		kind_t kind1;
		logic [7:0] value1;
		snap_t snap;
	} entry_t;

endpackage

// ===== src/s7rp_front.sv =====
// Parser front end: configuration registers and the per-byte PDU state machine.
// Depends on s7rp_pkg; pushes one entry per result-producing byte into the queue.
module s7rp_front
	import s7rp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_ADDR_W-1:0] cfg_addr,
	input logic [CFG_DATA_W-1:0] cfg_wdata,
	input logic in_fire,
	input logic [7:0] data_byte,
	input logic frame_end,
	output logic push,
	output entry_t push_entry
);

	logic [7:0] protocol_id_q, ack_data_type_q, size_bit_q, size_byte_q, size_int_q;

	phase_t phase_q, phase_d;
	logic [3:0] hdr_idx_q, hdr_idx_d;
	logic [7:0] type_q, type_d;
	logic [15:0] ref_q, ref_d;
	logic [15:0] plen_q, plen_d;
	logic [15:0] dlen_q, dlen_d;
	logic [15:0] ack_err_q, ack_err_d;
	logic [15:0] sec_rem_q, sec_rem_d;
	logic [23:0] ihb_q, ihb_d;
	logic [1:0] ihi_q, ihi_d;
	logic [15:0] item_rem_q, item_rem_d;
	logic pad_q, pad_d;
	logic [7:0] rc_q, rc_d;
	logic [7:0] sz_q, sz_d;
	logic [15:0] len_q, len_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			protocol_id_q <= RST_PROTOCOL_ID;
			ack_data_type_q <= RST_ACK_DATA_TYPE;
			size_bit_q <= RST_SIZE_BIT;
			size_byte_q <= RST_SIZE_BYTE;
			size_int_q <= RST_SIZE_INT;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_PROTOCOL_ID: protocol_id_q <= cfg_wdata;
				REG_ACK_DATA_TYPE: ack_data_type_q <= cfg_wdata;
				REG_SIZE_BIT: size_bit_q <= cfg_wdata;
				REG_SIZE_BYTE: size_byte_q <= cfg_wdata;
				REG_SIZE_INT: size_int_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hdr_idx_q <= '0;
			type_q <= '0;
			ref_q <= '0;
			plen_q <= '0;
			dlen_q <= '0;
			ack_err_q <= '0;
			sec_rem_q <= '0;
			ihb_q <= '0;
			ihi_q <= '0;
			item_rem_q <= '0;
			pad_q <= 1'b0;
			rc_q <= '0;
			sz_q <= '0;
			len_q <= '0;
		end else if (in_fire) begin
			phase_q <= phase_d;
			hdr_idx_q <= hdr_idx_d;
			type_q <= type_d;
			ref_q <= ref_d;
			plen_q <= plen_d;
			dlen_q <= dlen_d;
			ack_err_q <= ack_err_d;
			sec_rem_q <= sec_rem_d;
			ihb_q <= ihb_d;
			ihi_q <= ihi_d;
			item_rem_q <= item_rem_d;
			pad_q <= pad_d;
			rc_q <= rc_d;
			sz_q <= sz_d;
			len_q <= len_d;
		end
	end

	// Result sources in emission order: one from the phase itself, the frame-done of
	// the item walker, and the truncation error raised by the buffer end.
	logic a_valid, b_valid, c_valid;
	kind_t a_kind;
	logic [7:0] a_value, c_value;
	logic a_iend;
	logic enter_data, do_next;
	logic [3:0] hdr_len;
	logic [15:0] raw_len, item_len;
	logic [16:0] raw_round;

	always_comb begin
		phase_d = phase_q;
		hdr_idx_d = hdr_idx_q;
		type_d = type_q;
		ref_d = ref_q;
		plen_d = plen_q;
		dlen_d = dlen_q;
		ack_err_d = ack_err_q;
		sec_rem_d = sec_rem_q;
		ihb_d = ihb_q;
		ihi_d = ihi_q;
		item_rem_d = item_rem_q;
		pad_d = pad_q;
		rc_d = rc_q;
		sz_d = sz_q;
		len_d = len_q;
		a_valid = 1'b0;
		a_kind = KIND_HDR;
		a_value = '0;
		a_iend = 1'b0;
		b_valid = 1'b0;
		c_valid = 1'b0;
		c_value = '0;
		enter_data = 1'b0;
		do_next = 1'b0;
		hdr_len = HDR_LEN_PLAIN;
		raw_len = {ihb_q[7:0], data_byte};
		raw_round = 17'(raw_len) + 17'd7;
		item_len = raw_len;

		unique case (phase_q)
			PH_HEADER: begin
				if (hdr_idx_q == 4'd0) begin
					type_d = '0;
					ref_d = '0;
					plen_d = '0;
					dlen_d = '0;
					ack_err_d = '0;
					rc_d = '0;
					sz_d = '0;
					len_d = '0;
				end
				if (hdr_idx_q == 4'd0 && data_byte != protocol_id_q) begin
					a_valid = 1'b1;
					a_kind = KIND_ERR;
					a_value = ERR_BAD_ID;
					phase_d = PH_SKIP;
				end else begin
					case (hdr_idx_q)
						4'd1: type_d = data_byte;
						4'd4: ref_d[15:8] = data_byte;
						4'd5: ref_d[7:0] = data_byte;
						4'd6: plen_d[15:8] = data_byte;
						4'd7: plen_d[7:0] = data_byte;
						4'd8: dlen_d[15:8] = data_byte;
						4'd9: dlen_d[7:0] = data_byte;
						4'd10: ack_err_d[15:8] = data_byte;
						4'd11: ack_err_d[7:0] = data_byte;
						default: ;
					endcase
					hdr_idx_d = hdr_idx_q + 4'd1;
					hdr_len = (type_d == ack_data_type_q) ? HDR_LEN_ACK : HDR_LEN_PLAIN;
					if (hdr_idx_d >= hdr_len) begin
						hdr_idx_d = '0;
						a_valid = 1'b1;
						a_kind = KIND_HDR;
						if (plen_d != 16'd0) begin
							sec_rem_d = plen_d;
							phase_d = PH_PARAM;
						end else begin
							enter_data = 1'b1;
						end
					end
				end
			end
			PH_PARAM: begin
				a_valid = 1'b1;
				a_kind = KIND_PARAM;
				a_value = data_byte;
				sec_rem_d = sec_rem_q - 16'd1;
				if (sec_rem_d == 16'd0)
					enter_data = 1'b1;
			end
			PH_ITEM_HDR: begin
				sec_rem_d = sec_rem_q - 16'd1;
				if (ihi_q != 2'd3) begin
					ihb_d = {ihb_q[15:0], data_byte};
					ihi_d = ihi_q + 2'd1;
				end else begin
					ihi_d = '0;
					rc_d = ihb_q[23:16];
					sz_d = ihb_q[15:8];
					// Lengths of the bit, byte and int size codes count bits and round up to whole bytes.
					if (sz_d == size_bit_q || sz_d == size_byte_q || sz_d == size_int_q)
						item_len = {2'b00, raw_round[16:3]};
					len_d = item_len;
					a_valid = 1'b1;
					if (item_len > sec_rem_d) begin
						a_kind = KIND_ERR;
						a_value = ERR_ITEM_OVERRUN;
						phase_d = PH_SKIP;
					end else begin
						a_kind = KIND_ITEM_HDR;
						item_rem_d = item_len;
						pad_d = item_len[0];
						if (item_len == 16'd0)
							do_next = 1'b1;
						else
							phase_d = PH_ITEM_DATA;
					end
				end
			end
			PH_ITEM_DATA: begin
				sec_rem_d = sec_rem_q - 16'd1;
				item_rem_d = item_rem_q - 16'd1;
				a_valid = 1'b1;
				a_kind = KIND_ITEM;
				a_value = data_byte;
				a_iend = (item_rem_d == 16'd0);
				if (item_rem_d == 16'd0) begin
					if (pad_q && sec_rem_d != 16'd0) begin
						pad_d = 1'b0;
						phase_d = PH_PAD;
					end else begin
						do_next = 1'b1;
					end
				end
			end
			PH_PAD: begin
				sec_rem_d = sec_rem_q - 16'd1;
				do_next = 1'b1;
			end
			PH_TAIL: begin
				sec_rem_d = sec_rem_q - 16'd1;
				if (sec_rem_d == 16'd0) begin
					a_valid = 1'b1;
					a_kind = KIND_FRAME;
					phase_d = PH_DONE;
				end
			end
			default: ;
		endcase

		if (enter_data) begin
			sec_rem_d = dlen_d;
			do_next = 1'b1;
		end

		if (do_next) begin
			ihi_d = '0;
			ihb_d = '0;
			pad_d = 1'b0;
			if (sec_rem_d == 16'd0) begin
				b_valid = 1'b1;
				phase_d = PH_DONE;
			end else if (sec_rem_d < ITEM_HDR_LEN) begin
				phase_d = PH_TAIL;
			end else begin
				phase_d = PH_ITEM_HDR;
			end
		end

		if (frame_end) begin
			if (!(phase_d inside {PH_DONE, PH_SKIP})) begin
				c_valid = 1'b1;
				c_value = (phase_d == PH_HEADER) ? ERR_SHORT_HDR : ERR_SHORT_FRAME;
			end
			phase_d = PH_HEADER;
			hdr_idx_d = '0;
			ihi_d = '0;
			ihb_d = '0;
			pad_d = 1'b0;
		end
	end

	// Pack the sources into at most two result slots.
	always_comb begin
		push_entry.snap.msg_type = type_d;
		push_entry.snap.pdu_reference = ref_d;
		push_entry.snap.param_length = plen_d;
		push_entry.snap.data_length = dlen_d;
		push_entry.snap.ack_error = ack_err_d;
		push_entry.snap.item_return_code = rc_d;
		push_entry.snap.item_size_code = sz_d;
		push_entry.snap.item_bytes = len_d;
		push_entry.kind0 = KIND_ERR;
		push_entry.value0 = c_value;
		push_entry.item_end0 = 1'b0;
		push_entry.kind1 = KIND_ERR;
		push_entry.value1 = c_value;
		push_entry.count = {1'b0, c_valid};
		if (a_valid) begin
			push_entry.kind0 = a_kind;
			push_entry.value0 = a_value;
			push_entry.item_end0 = a_iend;
			push_entry.count = (b_valid || c_valid) ? 2'd2 : 2'd1;
			if (b_valid) begin
				push_entry.kind1 = KIND_FRAME;
				push_entry.value1 = '0;
			end
		end else if (b_valid) begin
			push_entry.kind0 = KIND_FRAME;
			push_entry.value0 = '0;
			push_entry.count = c_valid ? 2'd2 : 2'd1;
		end
	end

	assign push = in_fire && (push_entry.count != 2'd0);

endmodule

// ===== src/s7rp_queue.sv =====
// Short result queue between the parser front end and the output stage.
// Depends on s7rp_pkg for the entry type; storage is a small register array.
`include "s7_response_pdu_parser_macros.svh"

module s7rp_queue
	import s7rp_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input entry_t push_entry,
	input logic pop,
	output entry_t head,
	output logic empty,
	output logic full
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == CNT_W'(0));
	assign full = (count_q == CNT_W'(DEPTH));
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	`S7RP_ASSERT_IMPL(a_no_overflow, push, !full, "queue push while full")
	`S7RP_ASSERT_IMPL(a_no_underflow, pop, !empty, "queue pop while empty")

endmodule

// ===== src/s7rp_back.sv =====
// Output stage: unpacks queue entries into single results on the master stream.
// Depends on s7rp_pkg; holds the output register and the slot selector of a pair.
`include "s7_response_pdu_parser_macros.svh"

module s7rp_back
	import s7rp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input entry_t head,
	input logic empty,
	output logic pop,
	output logic m_tvalid,
	input logic m_tready,
	output logic [TDATA_W-1:0] m_tdata,
	output logic [TUSER_W-1:0] m_tuser,
	output logic m_tlast
);

	logic valid_q;
	logic second_q;
	logic [TDATA_W-1:0] data_q;
	logic [TUSER_W-1:0] kind_q;
	logic last_q;
	logic load;
	logic take_first;
	logic [7:0] value_sel;
	logic iend_sel;
	kind_t kind_sel;

	assign load = !valid_q || m_tready;
	// The first result of a pair leaves the entry in place for its sibling.
	assign take_first = !second_q && (head.count == 2'd2);
	assign pop = load && !empty && !take_first;

	always_comb begin
		if (second_q) begin
			kind_sel = head.kind1;
			value_sel = head.value1;
			iend_sel = 1'b0;
		end else begin
			kind_sel = head.kind0;
			value_sel = head.value0;
			iend_sel = head.item_end0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty)
				second_q <= take_first;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			kind_q <= kind_sel;
			last_q <= !take_first;
			data_q <= {7'd0, iend_sel, head.snap.item_bytes, head.snap.item_size_code,
				head.snap.item_return_code, head.snap.ack_error, head.snap.data_length,
				head.snap.param_length, head.snap.pdu_reference, head.snap.msg_type,
				value_sel};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = data_q;
	assign m_tuser = kind_q;
	assign m_tlast = last_q;

	`S7RP_ASSERT_IMPL(a_head_nonempty, !empty, head.count != 2'd0,
		"queue entry without results")
	`S7RP_ASSERT_IMPL(a_sibling_held, valid_q && !last_q, !empty && second_q,
		"first result of a pair shown without its sibling queued")

endmodule

// ===== src/s7_response_pdu_parser.sv =====
// Top level of the S7 response PDU parser.
// Depends on s7rp_pkg and instantiates s7rp_front, s7rp_queue and s7rp_back.

// The parser takes one S7comm response PDU per buffer, one byte per request on the
// slave stream, with s_tlast on the last byte held in the buffer. The front end
// consumes a byte in every cycle that the queue has room: it checks the protocol
// id, gathers the 10-byte header (12 bytes when the message type matches
// ack_data_type), passes parameter bytes through, and walks the data section item
// by item. Each byte yields zero, one or two results; they are written together as
// one entry into a short queue, and the output stage sends them one per cycle on
// the master stream while m_tready is high. So a byte that produces at most one
// result sustains one byte per cycle; the queue of QUEUE_DEPTH entries absorbs the
// bursts of bytes that produce two (e.g. header done followed by frame done or
// by a truncation error) and stalls on the output side. The top level holds
// s_tready high whenever the queue has room, so input is taken while finished
// results still wait on the output. Results carry the header values gathered so
// far and the latest item header. Configuration writes take effect on the clock
// edge at which cfg_we is high and should be issued only while the block is idle.
module s7_response_pdu_parser
	import s7rp_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	// Configuration: 0 protocol_id, 1 ack_data_type, 2 size_code_bit,
	// 3 size_code_byte, 4 size_code_int.
	input logic cfg_we,
	input logic [CFG_ADDR_W-1:0] cfg_addr,
	input logic [CFG_DATA_W-1:0] cfg_wdata,
	input logic s_tvalid,
	output logic s_tready,
	input logic [S_TDATA_W-1:0] s_tdata, // [7:0] data_byte
	input logic s_tlast, // frame_end
	output logic m_tvalid,
	input logic m_tready,
	// [7:0] value_byte, [15:8] msg_type, [31:16] pdu_reference,
	// [47:32] param_length, [63:48] data_length, [79:64] ack_error,
	// [87:80] item_return_code, [95:88] item_size_code, [111:96] item_bytes,
	// [112] item_end, [119:113] zero
	output logic [TDATA_W-1:0] m_tdata,
	output logic [TUSER_W-1:0] m_tuser, // [2:0] kind
	output logic m_tlast // last
);

	logic in_fire;
	logic push, pop, empty, full;
	entry_t push_entry, head;

	// A byte is taken only when its results are certain to fit in the queue.
	assign s_tready = !full;
	assign in_fire = s_tvalid && s_tready;

	s7rp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_fire(in_fire),
		.data_byte(s_tdata),
		.frame_end(s_tlast),
		.push(push),
		.push_entry(push_entry)
	);

	s7rp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.pop(pop),
		.head(head),
		.empty(empty),
		.full(full)
	);

	s7rp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(empty),
		.pop(pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

endmodule
